/* design/cpc_pkg.sv */
`timescale 1ns / 1ps
// shared constants for the compressible page check
// register indexes, swizzle classes and fixed widths; no dependencies

package cpc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECURE_TOP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_CNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLICES     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PART_MAP   = 3'd5;

  // payload widths
  localparam int ADDR_W = 48;
  localparam int THR_W  = 51;

  // slice total that enables the partition logic
  localparam logic [9:0] SLICE_TOTAL = 10'd80;

  // swizzle classes
  localparam logic [2:0] CLS_PLAIN   = 3'd0;
  localparam logic [2:0] CLS_HALF    = 3'd1;
  localparam logic [2:0] CLS_QUARTER = 3'd2;
  localparam logic [2:0] CLS_EIGHTH  = 3'd3;
  localparam logic [2:0] CLS_ANY     = 3'd4;

endpackage

/* design/compressible_page_check.sv */
`timescale 1ns / 1ps
// compressible page check: decides whether a page may use lossless compression
// depends on cpc_pkg
//
// Usage:
// - configuration is written through cfg_wr_en / cfg_index / cfg_data while the
//   block holds no word; derived boundary values settle through the first and second
//   derived levels, so in_ready stays low during a write and in the cycle after it
// - input words (phys_addr, huge_page) enter on in_valid / in_ready, results
//   (compressible) leave on out_valid / out_ready
// - seven register stages (stages 1 to 6 and the output stage): the accepting edge
//   loads stage 1, and the word passes on through the rest to the output unless stalled
// - throughput is one word per cycle; every stage holds one word, so a full
//   pipeline takes a new word in every cycle the output is free and no write holds it
// - when the receiver stalls, the output register holds its word and the whole
//   pipeline freezes; in_ready drops until the output word is taken
// - reset clears the configuration and the valid bits and empties the pipeline
// - the huge page stripe scan is a closed-form test on the stripe index
//   modulo the swizzle period, done in the last two stages

module compressible_page_check
  import cpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADDR_W-1:0]     phys_addr,
  input  logic                  huge_page,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  compressible
);

  // configuration registers
  logic [31:0] bound_a;
  logic [31:0] bound_b;
  logic [47:0] secure_top;
  logic [5:0]  cache_count;
  logic [3:0]  slices_per_cache;
  logic [63:0] partition_map;
  logic        cfg_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_a          <= '0;
      bound_b          <= '0;
      secure_top       <= '0;
      cache_count      <= '0;
      slices_per_cache <= '0;
      partition_map    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BOUND_A:    bound_a          <= cfg_data[31:0];
        REG_BOUND_B:    bound_b          <= cfg_data[31:0];
        REG_SECURE_TOP: secure_top       <= cfg_data[47:0];
        REG_CACHE_CNT:  cache_count      <= cfg_data[5:0];
        REG_SLICES:     slices_per_cache <= cfg_data[3:0];
        REG_PART_MAP:   partition_map    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input hold-off while derived values catch up with a write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_hold <= 1'b0;
    end else begin
      cfg_hold <= cfg_wr_en;
    end
  end

  // first level of derived boundary values
  logic [35:0] top;
  logic [34:0] bottom;
  logic [34:0] part5b;
  logic        ls_ok;
  logic        cache_ok;
  logic        part_zero;
  logic [8:0]  t1;
  logic [8:0]  t2;

  logic [32:0] sum_ab;
  logic [9:0]  ls_prod;
  logic [11:0] offset;
  logic [15:0] offset10;

  always_comb begin
    sum_ab   = {1'b0, bound_a} + {1'b0, bound_b};
    ls_prod  = 10'(cache_count) * 10'(slices_per_cache);
    offset   = 12'd2048 - {1'b0, bound_a[6:0], 4'b0};
    offset10 = 16'(offset) * 16'd10;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top       <= '0;
      bottom    <= '0;
      part5b    <= '0;
      ls_ok     <= 1'b0;
      cache_ok  <= 1'b0;
      part_zero <= 1'b1;
      t1        <= '0;
      t2        <= '0;
    end else begin
      top       <= {1'b0, sum_ab, 2'b0} + 36'(sum_ab);
      bottom    <= {1'b0, bound_a, 2'b0} + 35'(bound_a);
      part5b    <= {1'b0, bound_b, 2'b0} + 35'(bound_b);
      ls_ok     <= (ls_prod == SLICE_TOTAL);
      cache_ok  <= (slices_per_cache == 4'd4) && (cache_count[1:0] == 2'b0)
                   && (cache_count != 6'd0);
      part_zero <= (bound_b == 32'd0);
      t1        <= offset10[15:7];
      t2        <= {1'b0, offset10[15:8]};
    end
  end

  // second level: addresses, partition thresholds, rebase offsets
  logic [50:0]      base_addr;
  logic [51:0]      top_addr;
  logic             elig_cfg;
  logic [THR_W-1:0] thr [8];
  logic [63:0]      coff1;
  logic [63:0]      coff2;
  logic [63:0]      coff3;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= '0;
      top_addr  <= '0;
      elig_cfg  <= 1'b0;
      coff1     <= '0;
      coff2     <= '0;
      coff3     <= '0;
      for (int k = 0; k < 8; k++) begin
        thr[k] <= '0;
      end
    end else begin
      base_addr <= {bottom, 16'b0};
      top_addr  <= {top, 16'b0};
      elig_cfg  <= cache_ok && (48'(top) < secure_top);
      coff1     <= 64'(160 * 65536) - ({55'b0, t1} << 17);
      coff2     <= 64'(160 * 65536) - ({55'b0, t1} << 16);
      coff3     <= 64'(80 * 65536) - ({55'b0, t2} << 16);
      for (int k = 0; k < 8; k++) begin
        thr[k] <= {38'(38'(part5b) * 38'(k)), 13'b0};
      end
    end
  end

  // pipeline advance: the output register is free or being taken
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !cfg_wr_en && !cfg_hold;

  // stage 1: capture word, secure window compare
  logic              v1;
  logic [ADDR_W-1:0] s1_pa;
  logic              s1_huge;
  logic              s1_lt_sec;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pa     <= phys_addr;
      s1_huge   <= huge_page;
      s1_lt_sec <= {16'b0, phys_addr} < {secure_top, 16'b0};
    end
  end

  // stage 2: offset into the partitioned region and eligibility
  logic              v2;
  logic [ADDR_W-1:0] s2_pa;
  logic              s2_huge;
  logic [THR_W-1:0]  s2_rel;
  logic              s2_elig;
  logic              s2_force;

  logic [51:0] rel_diff;
  logic        in_region;

  always_comb begin
    rel_diff  = {4'b0, s1_pa} - {1'b0, base_addr};
    in_region = !rel_diff[51] && ({4'b0, s1_pa} < top_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pa    <= s1_pa;
      s2_huge  <= s1_huge;
      s2_rel   <= rel_diff[THR_W-1:0];
      s2_elig  <= elig_cfg && s1_lt_sec && in_region;
      s2_force <= !ls_ok;
    end
  end

  // stage 3: partition index by threshold compare
  logic              v3;
  logic [ADDR_W-1:0] s3_pa;
  logic              s3_huge;
  logic [THR_W-1:0]  s3_rel;
  logic              s3_elig;
  logic              s3_force;
  logic [2:0]        s3_idx;

  logic [2:0] idx_cnt;

  always_comb begin
    idx_cnt = 3'd0;
    for (int k = 1; k < 8; k++) begin
      idx_cnt = idx_cnt + {2'b0, (s2_rel >= thr[k])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pa    <= s2_pa;
      s3_huge  <= s2_huge;
      s3_rel   <= s2_rel;
      s3_elig  <= s2_elig;
      s3_force <= s2_force || (s2_elig && part_zero);
      s3_idx   <= idx_cnt;
    end
  end

  // stage 4: swizzle id lookup and class decode
  logic              v4;
  logic [ADDR_W-1:0] s4_pa;
  logic              s4_huge;
  logic [THR_W-1:0]  s4_rel;
  logic              s4_elig;
  logic              s4_force;
  logic [2:0]        s4_cls;
  logic [2:0]        s4_k;

  logic [7:0] swz_id;
  logic [2:0] cls_c;
  logic [2:0] k_c;

  always_comb begin
    swz_id = s3_elig ? partition_map[{s3_idx, 3'b0} +: 8] : 8'd0;
    cls_c  = CLS_ANY;
    k_c    = 3'd0;
    if (swz_id == 8'd0) begin
      cls_c = CLS_PLAIN;
    end else if (swz_id <= 8'd2) begin
      cls_c = CLS_HALF;
      k_c   = {swz_id[1:0] - 2'd1, 1'b0} << 1;
    end else if (swz_id <= 8'd6) begin
      cls_c = CLS_QUARTER;
      k_c   = {swz_id[1:0] - 2'd3, 1'b0};
    end else if (swz_id <= 8'd14) begin
      cls_c = CLS_EIGHTH;
      k_c   = swz_id[2:0] - 3'd7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_pa    <= s3_pa;
      s4_huge  <= s3_huge;
      s4_rel   <= s3_rel;
      s4_elig  <= s3_elig;
      s4_force <= s3_force;
      s4_cls   <= cls_c;
      s4_k     <= k_c;
    end
  end

  // stage 5: rebased address
  logic        v5;
  logic        s5_huge;
  logic        s5_force;
  logic [2:0]  s5_cls;
  logic [63:0] s5_r;

  logic [63:0] coff_sel;
  logic [63:0] rebase;

  always_comb begin
    case (s4_cls)
      CLS_HALF:    coff_sel = coff1;
      CLS_QUARTER: coff_sel = coff2;
      default:     coff_sel = coff3;
    endcase
    rebase = {13'b0, s4_rel} - {13'b0, thr[s4_k]} + coff_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_huge  <= s4_huge;
      s5_force <= s4_force;
      s5_cls   <= s4_cls;
      s5_r     <= (s4_cls == CLS_PLAIN) ? {16'b0, s4_pa} : rebase;
    end
  end

  // stage 6: stripe index split, nibble sum for the mod 5 reduction
  logic       v6;
  logic       s6_huge;
  logic       s6_force;
  logic [2:0] s6_cls;
  logic [7:0] s6_nsum;
  logic [4:0] s6_low;
  logic       s6_wrap;

  logic [43:0] qhi;
  logic [4:0]  qlow;
  logic [7:0]  nsum;

  always_comb begin
    case (s5_cls)
      CLS_PLAIN: begin
        qhi  = {3'b0, s5_r[63:23]};
        qlow = s5_r[22:18];
      end
      CLS_HALF: begin
        qhi  = {2'b0, s5_r[63:22]};
        qlow = s5_r[21:17];
      end
      CLS_QUARTER: begin
        qhi  = {1'b0, s5_r[63:21]};
        qlow = s5_r[20:16];
      end
      default: begin
        qhi  = s5_r[63:20];
        qlow = {1'b0, s5_r[19:16]};
      end
    endcase
    // 16 is 1 mod 5, so the nibble sum keeps the residue
    nsum = 8'd0;
    for (int n = 0; n < 11; n++) begin
      nsum = nsum + {4'b0, qhi[4*n +: 4]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_huge  <= s5_huge;
      s6_force <= s5_force;
      s6_cls   <= s5_cls;
      s6_nsum  <= nsum;
      s6_low   <= qlow;
      s6_wrap  <= s5_huge && (&s5_r[63:21]);
    end
  end

  // output stage: residue, stripe position, reserved window test
  logic [4:0] fold_a;
  logic [4:0] fold_b;
  logic [2:0] m5;
  logic [7:0] qm;
  logic       hit;
  logic       answer;

  always_comb begin
    fold_a = {1'b0, s6_nsum[7:4]} + {1'b0, s6_nsum[3:0]};
    fold_b = {4'b0, fold_a[4]} + {1'b0, fold_a[3:0]};
    if (fold_b >= 5'd15) begin
      m5 = 3'(fold_b - 5'd15);
    end else if (fold_b >= 5'd10) begin
      m5 = 3'(fold_b - 5'd10);
    end else if (fold_b >= 5'd5) begin
      m5 = 3'(fold_b - 5'd5);
    end else begin
      m5 = fold_b[2:0];
    end
    if (s6_cls == CLS_EIGHTH) begin
      qm = {1'b0, m5, s6_low[3:0]};
    end else begin
      qm = {m5, s6_low};
    end
    case (s6_cls)
      CLS_PLAIN:   hit = (qm < 8'd3) || (s6_huge && (qm > 8'd152));
      CLS_HALF:    hit = (qm < 8'd4) || (s6_huge && (qm > 8'd144));
      CLS_QUARTER: hit = (qm < 8'd4) || (s6_huge && (qm > 8'd128));
      CLS_EIGHTH:  hit = (qm < 8'd3) || (s6_huge && (qm > 8'd48));
      default:     hit = 1'b0;
    endcase
    answer = s6_force || s6_wrap || !hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      compressible <= answer;
    end
  end

`ifndef ASSERT_OFF
  // slice total flag follows the cache registers
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ls_ok == $past(ls_prod == SLICE_TOTAL))
    else $error("slice total flag out of step");

  // an eligible offset lies inside the partitioned region
  assert property (@(posedge clk) disable iff (rst)
    v3 && s3_elig && !s3_force |-> s3_rel < {thr[4][THR_W-2:0], 1'b0})
    else $error("partition offset beyond region");

  // an ineligible word always takes the plain class
  assert property (@(posedge clk) disable iff (rst)
    v4 && !s4_elig |-> s4_cls == CLS_PLAIN)
    else $error("swizzle class without eligibility");

  // a stalled pipeline takes no new word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(v6) && $stable(s6_nsum))
    else $error("pipeline moved during stall");
`endif

endmodule
